// File: hw/rtl/gsbe_pkg.sv
package gsbe_pkg;

    localparam int unsigned MAX_BLOCK_BYTES_DEF = 65535;
    localparam int unsigned QUEUE_DEPTH         = 2;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // gzip member header bytes that are not zero, plus the BFINAL block header byte
    localparam logic [7:0] GZ_ID1   = 8'h1f;
    localparam logic [7:0] GZ_ID2   = 8'h8b;
    localparam logic [7:0] GZ_CM    = 8'h08;
    localparam logic [7:0] GZ_OS    = 8'h03;
    localparam logic [7:0] BFINAL   = 8'h01;

    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_EMPTY = 1'b1;

    // byte positions within one job's output sequence
    localparam logic [4:0] POS_HDR      = 5'd0;
    localparam logic [4:0] POS_HDR_LAST = 5'd9;
    localparam logic [4:0] POS_BLK      = 5'd10;
    localparam logic [4:0] POS_BLK_LAST = 5'd14;
    localparam logic [4:0] POS_DATA     = 5'd15;
    localparam logic [4:0] POS_TRL      = 5'd16;
    localparam logic [4:0] POS_SIZE     = 5'd20;
    localparam logic [4:0] POS_TRL_LAST = 5'd23;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       end_of_member;
    } out_item_t;

    // one classified item: which segments to emit and their contents
    typedef struct packed {
        logic        has_hdr;
        logic        has_blk;
        logic        blk_final;
        logic [15:0] blk_len;
        logic        has_data;
        logic [7:0]  data_byte;
        logic        has_trl;
        logic [31:0] trl_crc;
        logic [31:0] trl_size;
    } job_t;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    function automatic logic [7:0] gz_hdr_byte(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0:    r = GZ_ID1;
            4'd1:    r = GZ_ID2;
            4'd2:    r = GZ_CM;
            4'd9:    r = GZ_OS;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/gsbe_front.sv
module gsbe_front #(
    parameter int unsigned MAX_BLOCK_BYTES = gsbe_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  gsbe_pkg::in_item_t in_data,
    output logic              push,
    output gsbe_pkg::job_t    push_job,
    input  logic              q_full
);
    import gsbe_pkg::*;

    localparam logic [31:0] MAX32 = 32'(MAX_BLOCK_BYTES);
    localparam logic [15:0] MAX16 = 16'(MAX_BLOCK_BYTES);

    logic [31:0] msg_len_reg;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] bd_reg, bd_next;
    logic [15:0] bf_reg, bf_next;
    logic        in_member_reg, in_member_next;

    logic        take;
    logic        open;
    logic [31:0] base_bd, base_crc, crc_new, bd_new, remaining;
    logic [15:0] base_bf, bf_inc;
    logic        done;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;

    assign open      = !in_member_reg;
    assign base_bd   = open ? 32'd0 : bd_reg;
    assign base_bf   = open ? 16'd0 : bf_reg;
    assign base_crc  = open ? CRC_INIT : crc_reg;
    assign remaining = (msg_len_reg > base_bd) ? (msg_len_reg - base_bd) : 32'd1;
    assign crc_new   = crc32_byte(base_crc, in_data.data_byte);
    assign bd_new    = base_bd + 32'd1;
    assign bf_inc    = base_bf + 16'd1;
    assign done      = (bd_new >= msg_len_reg) || (bd_new == 32'd0);

    always_comb
    begin
        crc_next       = crc_reg;
        bd_next        = bd_reg;
        bf_next        = bf_reg;
        in_member_next = in_member_reg;
        push           = 1'b0;
        push_job       = '0;
        if (take)
        begin
            if (in_data.opcode == OP_EMPTY)
            begin
                push              = 1'b1;
                push_job.has_hdr  = 1'b1;
                push_job.has_blk  = 1'b1;
                push_job.blk_final = 1'b1;
                push_job.has_trl  = 1'b1;
                crc_next          = CRC_INIT;
                bd_next           = '0;
                bf_next           = '0;
                in_member_next    = 1'b0;
            end
            else if (!(open && msg_len_reg == 32'd0))
            begin
                push               = 1'b1;
                push_job.has_hdr   = open;
                push_job.has_blk   = (base_bf == 16'd0);
                push_job.blk_final = (remaining <= MAX32);
                push_job.blk_len   = (remaining > MAX32) ? MAX16 : remaining[15:0];
                push_job.has_data  = 1'b1;
                push_job.data_byte = in_data.data_byte;
                push_job.has_trl   = done;
                push_job.trl_crc   = ~crc_new;
                push_job.trl_size  = bd_new;
                if (done)
                begin
                    crc_next       = CRC_INIT;
                    bd_next        = '0;
                    bf_next        = '0;
                    in_member_next = 1'b0;
                end
                else
                begin
                    crc_next       = crc_new;
                    bd_next        = bd_new;
                    bf_next        = (bf_inc >= MAX16) ? 16'd0 : bf_inc;
                    in_member_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_len_reg   <= '0;
            crc_reg       <= CRC_INIT;
            bd_reg        <= '0;
            bf_reg        <= '0;
            in_member_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                msg_len_reg <= cfg_wdata;
            end
            crc_reg       <= crc_next;
            bd_reg        <= bd_next;
            bf_reg        <= bf_next;
            in_member_reg <= in_member_next;
        end
    end

endmodule

// File: hw/rtl/gsbe_queue.sv
module gsbe_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  gsbe_pkg::job_t push_job,
    output logic           full,
    output logic           head_valid,
    output gsbe_pkg::job_t head_job,
    input  logic           pop
);
    import gsbe_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full       = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: hw/rtl/gsbe_back.sv
module gsbe_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  gsbe_pkg::job_t     head_job,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output gsbe_pkg::out_item_t out_data
);
    import gsbe_pkg::*;

    logic       active_reg, active_next;
    logic [4:0] pos_reg, pos_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_data_reg, out_data_next;

    logic [4:0] cur_pos, first_pos, nxt_pos;
    logic       is_last, advance;
    logic [7:0] cur_byte;

    // first segment present in the job
    always_comb
    begin
        if (head_job.has_hdr)
            first_pos = POS_HDR;
        else if (head_job.has_blk)
            first_pos = POS_BLK;
        else if (head_job.has_data)
            first_pos = POS_DATA;
        else
            first_pos = POS_TRL;
    end

    assign cur_pos = active_reg ? pos_reg : first_pos;

    // step to the next byte, skipping absent segments
    always_comb
    begin
        nxt_pos = cur_pos + 5'd1;
        is_last = 1'b0;
        if (cur_pos == POS_HDR_LAST)
        begin
            if (head_job.has_blk)
                nxt_pos = POS_BLK;
            else if (head_job.has_data)
                nxt_pos = POS_DATA;
            else if (head_job.has_trl)
                nxt_pos = POS_TRL;
            else
                is_last = 1'b1;
        end
        else if (cur_pos == POS_BLK_LAST)
        begin
            if (head_job.has_data)
                nxt_pos = POS_DATA;
            else if (head_job.has_trl)
                nxt_pos = POS_TRL;
            else
                is_last = 1'b1;
        end
        else if (cur_pos == POS_DATA)
        begin
            if (head_job.has_trl)
                nxt_pos = POS_TRL;
            else
                is_last = 1'b1;
        end
        else if (cur_pos == POS_TRL_LAST)
        begin
            is_last = 1'b1;
        end
    end

    always_comb
    begin
        case (cur_pos) inside
            [POS_HDR:POS_HDR_LAST]: cur_byte = gz_hdr_byte(cur_pos[3:0]);
            POS_BLK:                cur_byte = head_job.blk_final ? BFINAL : 8'h00;
            5'd11:                  cur_byte = head_job.blk_len[7:0];
            5'd12:                  cur_byte = head_job.blk_len[15:8];
            5'd13:                  cur_byte = ~head_job.blk_len[7:0];
            POS_BLK_LAST:           cur_byte = ~head_job.blk_len[15:8];
            POS_DATA:               cur_byte = head_job.data_byte;
            5'd16:                  cur_byte = head_job.trl_crc[7:0];
            5'd17:                  cur_byte = head_job.trl_crc[15:8];
            5'd18:                  cur_byte = head_job.trl_crc[23:16];
            5'd19:                  cur_byte = head_job.trl_crc[31:24];
            POS_SIZE:               cur_byte = head_job.trl_size[7:0];
            5'd21:                  cur_byte = head_job.trl_size[15:8];
            5'd22:                  cur_byte = head_job.trl_size[23:16];
            POS_TRL_LAST:           cur_byte = head_job.trl_size[31:24];
            default:                cur_byte = 8'h00;
        endcase
    end

    assign advance = head_valid && (!out_valid_reg || out_ready);
    assign pop     = advance && is_last;

    always_comb
    begin
        active_next    = active_reg;
        pos_next       = pos_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (advance)
        begin
            out_valid_next              = 1'b1;
            out_data_next.out_byte      = cur_byte;
            out_data_next.last_of_run   = is_last;
            out_data_next.end_of_member = (cur_pos == POS_TRL_LAST);
            active_next                 = !is_last;
            pos_next                    = nxt_pos;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            pos_reg       <= POS_HDR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: hw/rtl/gzip_stored_block_encoder.sv
// channel  | signals                         | transfer when
// ---------+---------------------------------+-----------------------
// in       | in_valid, in_ready, in_data     | in_valid & in_ready
// out      | out_valid, out_ready, out_data  | out_valid & out_ready
// cfg      | cfg_we, cfg_wdata               | cfg_we (no wait)
//
// Each input item yields as many output bytes as its job holds: one for a
// plain data byte, up to 24 for a member that opens and closes on one item.
// The output sequencer emits one byte a cycle unless out_ready stalls it.
// An accepted item passes through the job queue and then the output register.
// Reset is immediate, no clearing pass. Either side may stall independently;
// the two-entry job queue absorbs the difference.
module gzip_stored_block_encoder #(
    parameter int unsigned MAX_BLOCK_BYTES = gsbe_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  gsbe_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output gsbe_pkg::out_item_t out_data
);
    import gsbe_pkg::*;

    logic push, q_full, head_valid, pop;
    job_t push_job, head_job;

    // front: holds message length, CRC and byte counts; classifies each
    // transfer into a job (header / block header / data / trailer)
    gsbe_front #(
        .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .push     (push),
        .push_job (push_job),
        .q_full   (q_full)
    );

    // job queue decoupling classification from byte emission
    gsbe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (q_full),
        .head_valid(head_valid),
        .head_job  (head_job),
        .pop       (pop)
    );

    // back: walks each job one byte per cycle into the output register, unless out_ready stalls it
    gsbe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_valid(head_valid),
        .head_job  (head_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// File: hw/rtl/gsbe_checker.sv
module gsbe_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input gsbe_pkg::out_item_t out_data
);
    import gsbe_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    // member end is always the last byte of its item
    a_eom_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.end_of_member |-> out_data.last_of_run)
        else $error("end_of_member without last_of_run");

    // no output in the first cycle after reset
    a_rst_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !out_valid)
        else $error("output valid right after reset");

    // an empty output stage means the queue has room
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output idle");

endmodule

bind gzip_stored_block_encoder gsbe_checker u_gsbe_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
);

// File: dv/tb_gzip_stored_block_encoder.sv
module tb_gzip_stored_block_encoder;

    timeunit 1ns;
    timeprecision 1ps;

    import gsbe_pkg::*;

    // Block size as the block is built; random members marked huge open a
    // full, non-final block.
    localparam int unsigned BLOCK_MAX = MAX_BLOCK_BYTES_DEF;

    // An accepted item passes the job queue and the output register and yields at
    // most 24 output bytes, so this many quiet cycles means the block is idle.
    localparam int DRAIN_CYCLES = 40;

    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT = 4000;

    // Random part: result-producing items per idling phase.
    localparam int PHASE_ITEMS = 105;

    // Fixed 10-byte gzip header: ID1 ID2 CM FLG MTIME(4) XFL OS.
    localparam logic [0:9][7:0] GZ_HEADER =
        {GZ_ID1, GZ_ID2, GZ_CM, 8'h00, 32'h0000_0000, 8'h00, GZ_OS};

    // Whole member for an empty-member request: header, empty final block,
    // zero CRC, zero size (last byte is padding).
    localparam logic [0:23][7:0] EMPTY_MEMBER =
        192'h1f8b0800000000000003_010000ffff_0000000000000000_00;

    // Whole member for a one-byte message holding 0x00 (CRC 0xD202EF8D).
    localparam logic [0:23][7:0] ZERO_BYTE_MEMBER =
        192'h1f8b0800000000000003_010100feff_00_8def02d2_01000000;

    typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_t;

    typedef struct {
        row_kind_t        kind;
        logic [31:0]      length;
        in_item_t         item;
        bit               typed;       // expectation written out below
        int               typed_n;
        logic [0:23][7:0] typed_bytes;
    } corner_row_t;

    // ------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = 32'd0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    in_item_t    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;

    gzip_stored_block_encoder #(
        .MAX_BLOCK_BYTES(BLOCK_MAX)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Encoder model state: message length register plus the open member
    // ------------------------------------------------------------------
    logic [31:0] len_reg;
    logic [31:0] crc_reg;
    logic [31:0] member_bytes;
    int          block_bytes;
    bit          member_open;

    out_item_t   item_bytes[$];    // bytes the current item yields
    out_item_t   stream_due[$];    // gzip stream still owed by the block
    corner_row_t corner_rows[$];

    int send_idle_pct = 33;
    int recv_idle_pct = 55;

    int fail_count     = 0;
    int in_transfers   = 0;
    int ignored_items  = 0;
    int bytes_checked  = 0;
    int members_closed = 0;

    function automatic void push_byte(input logic [7:0] b, input logic eom);
        item_bytes.push_back('{out_byte: b, last_of_run: 1'b0, end_of_member: eom});
    endfunction

    function automatic void emit_header();
        for (int i = 0; i < 10; i++)
            push_byte(GZ_HEADER[i], 1'b0);
    endfunction

    // stored block header: BFINAL, LEN and NLEN little-endian
    function automatic void emit_block_header(input logic [15:0] blk_len,
                                              input bit is_final);
        push_byte(is_final ? BFINAL : 8'h00, 1'b0);
        push_byte(blk_len[7:0], 1'b0);
        push_byte(blk_len[15:8], 1'b0);
        push_byte(~blk_len[7:0], 1'b0);
        push_byte(~blk_len[15:8], 1'b0);
    endfunction

    function automatic void emit_trailer(input logic [31:0] crc, input logic [31:0] size);
        for (int i = 0; i < 4; i++)
            push_byte(crc[8*i +: 8], 1'b0);
        for (int i = 0; i < 4; i++)
            push_byte(size[8*i +: 8], i == 3);
    endfunction

    function automatic void close_member();
        crc_reg      = CRC_INIT;
        member_bytes = 32'd0;
        block_bytes  = 0;
        member_open  = 1'b0;
    endfunction

    // Works out the bytes one accepted item yields and advances the model.
    function automatic void encode_item(input in_item_t it);
        logic [31:0] left;
        logic [15:0] blk_len;
        item_bytes.delete();
        if (it.opcode == OP_EMPTY)
        begin
            // drops any open member without a trailer
            close_member();
            emit_header();
            emit_block_header(16'd0, 1'b1);
            emit_trailer(32'd0, 32'd0);
        end
        else
        begin
            // idle with a zero length: byte swallowed
            if (!member_open && len_reg == 32'd0)
                return;
            if (!member_open)
            begin
                close_member();
                member_open = 1'b1;
                emit_header();
            end
            if (block_bytes == 0)
            begin
                // length at or below the count so far: this byte is the last
                left    = (len_reg > member_bytes) ? len_reg - member_bytes : 32'd1;
                blk_len = (left > BLOCK_MAX) ? 16'(BLOCK_MAX) : left[15:0];
                emit_block_header(blk_len, left <= BLOCK_MAX);
            end
            push_byte(it.data_byte, 1'b0);
            crc_reg = crc_reg ^ {24'd0, it.data_byte};
            for (int b = 0; b < 8; b++)
                crc_reg = (crc_reg >> 1) ^ (CRC_POLY & {32{crc_reg[0]}});
            member_bytes = member_bytes + 32'd1;
            block_bytes  = block_bytes + 1;
            if (block_bytes >= BLOCK_MAX)
                block_bytes = 0;
            if (member_bytes >= len_reg || member_bytes == 32'd0)
            begin
                emit_trailer(~crc_reg, member_bytes);
                close_member();
            end
        end
        if (item_bytes.size() != 0)
            item_bytes[item_bytes.size() - 1].last_of_run = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus side
    // ------------------------------------------------------------------

    // One input transfer. Valid is raised after a random gap and held until
    // accepted. The model advances at the accepting edge; its bytes are
    // queued unless the caller supplies a written-out expectation.
    task automatic send_item(input in_item_t it, input bit queue_model);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        in_transfers++;
        encode_item(it);
        if (item_bytes.size() == 0)
            ignored_items++;
        if (queue_model)
            foreach (item_bytes[k])
                stream_due.push_back(item_bytes[k]);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item('{opcode: OP_DATA, data_byte: b}, 1'b1);
    endtask

    task automatic send_empty(input logic [7:0] b);
        send_item('{opcode: OP_EMPTY, data_byte: b}, 1'b1);
    endtask

    // Length register writes happen only with the block quiet: input idle,
    // every owed byte delivered, then the drain allowance for swallowed items.
    task automatic write_length(input logic [31:0] value);
        in_valid <= 1'b0;
        while (stream_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        len_reg = value;
    endtask

    function automatic void row_cfg(input logic [31:0] value);
        corner_rows.push_back('{ROW_CFG, value, '0, 1'b0, 0, '0});
    endfunction

    function automatic void row_item(input logic op, input logic [7:0] b);
        corner_rows.push_back('{ROW_ITEM, 32'd0, '{opcode: op, data_byte: b}, 1'b0, 0, '0});
    endfunction

    function automatic void row_typed(input logic op, input logic [7:0] b, input int n,
                                      input logic [0:23][7:0] bytes);
        corner_rows.push_back('{ROW_ITEM, 32'd0, '{opcode: op, data_byte: b}, 1'b1, n, bytes});
    endfunction

    // Random traffic, mostly well-formed members with random content.
    task automatic run_random(input int target);
        int          start;
        int          pick;
        int          len;
        int          cut;
        int          sent;
        int          n;
        logic [31:0] huge;
        start = in_transfers - ignored_items;
        while (in_transfers - ignored_items - start < target)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                // short member; now and then the length is rewritten part way,
                // lower, higher or to zero
                len  = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, 12);
                cut  = (len > 1 && $urandom_range(4) == 0) ? $urandom_range(1, len - 1) : -1;
                write_length(32'(len));
                sent = 0;
                do
                begin
                    if (sent == cut)
                        write_length($urandom_range(0, len + 3));
                    send_byte(8'($urandom_range(255)));
                    sent++;
                end
                while (member_open);
            end
            else if (pick < 78)
            begin
                // member abandoned by an empty-member request
                len = $urandom_range(2, 20);
                write_length(32'(len));
                n = $urandom_range(0, len - 1);
                repeat (n) send_byte(8'($urandom_range(255)));
                send_empty(8'($urandom_range(255)));
            end
            else if (pick < 90)
            begin
                // length beyond one block: LEN 0xffff, not final
                huge = $urandom_range(1) ? 32'hFFFF_FFFF : ($urandom() | 32'h0001_0000);
                write_length(huge);
                n = $urandom_range(1, 6);
                repeat (n) send_byte(8'($urandom_range(255)));
                if ($urandom_range(1))
                begin
                    send_empty(8'($urandom_range(255)));
                end
                else
                begin
                    write_length($urandom_range(0, n));
                    send_byte(8'($urandom_range(255)));
                end
            end
            else
            begin
                // zero length while idle: data bytes swallowed
                write_length(0);
                n = $urandom_range(1, 4);
                repeat (n)
                begin
                    if ($urandom_range(3) == 0)
                        send_empty(8'($urandom_range(255)));
                    else
                        send_byte(8'($urandom_range(255)));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random backpressure, check each transfer in order
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : out_check
        out_item_t want;
        if (out_valid && out_ready)
        begin
            bytes_checked++;
            if (out_data.end_of_member)
                members_closed++;
            if (stream_due.size() == 0)
            begin
                if (fail_count < 10)
                    $display("unexpected output byte %02h last %0b eom %0b",
                             out_data.out_byte, out_data.last_of_run,
                             out_data.end_of_member);
                fail_count++;
            end
            else
            begin
                want = stream_due.pop_front();
                if (out_data.out_byte !== want.out_byte ||
                    out_data.last_of_run !== want.last_of_run ||
                    out_data.end_of_member !== want.end_of_member)
                begin
                    if (fail_count < 10)
                        $display({"output %0d: expected byte %02h last %0b eom %0b,",
                                  " got byte %02h last %0b eom %0b"},
                                 bytes_checked, want.out_byte, want.last_of_run,
                                 want.end_of_member, out_data.out_byte,
                                 out_data.last_of_run, out_data.end_of_member);
                    fail_count++;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Hang detection: too long without a transfer on either channel.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        len_reg = 32'd0;
        close_member();

        // corner table; rows with a written-out expectation are the ones
        // readable at a glance, the rest go through the model
        row_typed(OP_DATA, 8'hA5, 0, '0);                 // length 0 after reset
        row_cfg(32'd1);
        row_typed(OP_DATA, 8'h00, 24, ZERO_BYTE_MEMBER);  // open and close on one item
        row_typed(OP_EMPTY, 8'hFF, 23, EMPTY_MEMBER);     // data field ignored
        row_cfg(32'd3);
        row_item(OP_DATA, 8'hFF);
        row_item(OP_DATA, 8'h80);
        row_item(OP_DATA, 8'h01);
        row_cfg(32'hFFFF_FFFF);                           // largest length
        row_item(OP_DATA, 8'h5A);
        row_item(OP_DATA, 8'h7F);
        row_typed(OP_EMPTY, 8'h00, 23, EMPTY_MEMBER);     // abandons the open member
        row_cfg(32'd4);
        row_item(OP_DATA, 8'h11);
        row_item(OP_DATA, 8'h22);
        row_cfg(32'd1);                                   // lowered under the count
        row_item(OP_DATA, 8'h33);
        row_cfg(32'd5);
        row_item(OP_DATA, 8'h44);
        row_cfg(32'd0);                                   // zero while a member is open
        row_item(OP_DATA, 8'h55);
        row_item(OP_DATA, 8'h66);                         // idle, zero: swallowed
        row_item(OP_EMPTY, 8'hC3);
        row_cfg(32'd2);
        row_item(OP_DATA, 8'h00);
        row_item(OP_DATA, 8'hFF);

        // reset once, released on an edge
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phase 1: sender idles 33%, receiver 55%
        send_idle_pct = 33;
        recv_idle_pct = 55;
        foreach (corner_rows[i])
        begin
            if (corner_rows[i].kind == ROW_CFG)
            begin
                write_length(corner_rows[i].length);
            end
            else
            begin
                send_item(corner_rows[i].item, !corner_rows[i].typed);
                for (int k = 0; k < corner_rows[i].typed_n; k++)
                    stream_due.push_back('{out_byte:      corner_rows[i].typed_bytes[k],
                                           last_of_run:   k == corner_rows[i].typed_n - 1,
                                           end_of_member: k == corner_rows[i].typed_n - 1});
            end
        end
        run_random(PHASE_ITEMS);

        // phase 2: roles swapped
        write_length(32'd0);
        send_idle_pct = 55;
        recv_idle_pct = 33;
        run_random(PHASE_ITEMS);

        // phase 3: no idling either side
        write_length(32'd0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(PHASE_ITEMS);

        // drain and watch for stray output
        in_valid <= 1'b0;
        while (stream_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d input transfers (%0d swallowed), %0d output bytes, %0d members closed",
                 in_transfers, ignored_items, bytes_checked, members_closed);
        $display("run: three idling phases, mid-member length changes, abandoned members");
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/gsbe_pkg.sv
hw/rtl/gsbe_front.sv
hw/rtl/gsbe_queue.sv
hw/rtl/gsbe_back.sv
hw/rtl/gzip_stored_block_encoder.sv
hw/rtl/gsbe_checker.sv
dv/tb_gzip_stored_block_encoder.sv
